>>> src/mebs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and saturation helper for the motion estimator.
package mebs_pkg;

  localparam int POSITION_BITS = 32;
  localparam int NUM_AXES      = 3;
  localparam int DATA_W        = 48;
  localparam int MUL_A_W       = 33;
  localparam int MUL_B_W       = 35;
  localparam int PROD_W        = MUL_A_W + MUL_B_W;
  localparam int ACC_W         = 88;
  localparam int XS_W          = DATA_W + 3;
  localparam int SPLIT         = 17;
  localparam int COEF_FRAC     = 30;
  localparam int SQ_W          = 64;
  localparam int MAG_LOW_W     = 32;
  localparam int STEP_W        = 4;

  localparam logic [2:0]  COUNT_MAX     = 3'd5;
  localparam logic [2:0]  VEL_COUNT     = 3'd3;
  localparam logic [2:0]  ACC_COUNT     = 3'd5;
  localparam logic [15:0] RATE_RESET    = 16'd1000;
  localparam logic [31:0] RATE_SQ_RESET = 32'd1000000;

  localparam logic [2:0] REG_SAMPLE_RATE = 3'd0;
  localparam logic [2:0] REG_LPF_B0      = 3'd1;
  localparam logic [2:0] REG_LPF_A1      = 3'd2;
  localparam logic [2:0] REG_LPF_A2      = 3'd3;
  localparam logic [2:0] REG_VEL_THR     = 3'd4;
  localparam logic [2:0] REG_ACC_THR     = 3'd5;

  localparam logic [STEP_W-1:0] STEP_MUL_VEL   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_RAW   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_A1_LO = 4'd2;
  localparam logic [STEP_W-1:0] STEP_MUL_A1_HI = 4'd3;
  localparam logic [STEP_W-1:0] STEP_MUL_A2_LO = 4'd4;
  localparam logic [STEP_W-1:0] STEP_MUL_A2_HI = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MUL_B0_LO = 4'd6;
  localparam logic [STEP_W-1:0] STEP_MUL_B0_HI = 4'd7;
  localparam logic [STEP_W-1:0] STEP_MUL_VSQ   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_FILT      = 4'd9;
  localparam logic [STEP_W-1:0] STEP_MUL_ASQ   = 4'd10;
  localparam logic [STEP_W-1:0] STEP_LAST      = 4'd11;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_MERGE
  } state_t;

  typedef struct packed {
    logic              start;
    logic              run;
    logic [STEP_W-1:0] step;
    logic              do_vel;
    logic              do_acc;
  } lane_ctrl_t;

  typedef struct packed {
    logic        [15:0] rate;
    logic        [31:0] rate_sq;
    logic signed [31:0] b0;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
  } coef_t;

  typedef struct packed {
    logic [SQ_W-1:0] vsq;
    logic            vbig;
    logic [SQ_W-1:0] asq;
    logic            abig;
  } mag_t;

  function automatic logic signed [DATA_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] top;
    logic signed [DATA_W-1:0] r;
    top = v[ACC_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      r = v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> src/mebs_lane.sv
`timescale 1ns / 1ps
// One axis lane: differences, shared multiplier, biquad accumulate, squared magnitudes.
module mebs_lane import mebs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [31:0]              pos,
  input  lane_ctrl_t               ctrl,
  input  coef_t                    coef,
  output logic signed [DATA_W-1:0] vel,
  output logic signed [DATA_W-1:0] filt,
  output mag_t                     mag
);

  logic signed [POSITION_BITS-1:0] pos_s;
  logic signed [POSITION_BITS-1:0] p0, p1;
  logic signed [POSITION_BITS:0]   d1, d1_next;
  logic signed [POSITION_BITS+1:0] d2, d2_next;
  logic signed [MUL_A_W-1:0]       op_a;
  logic signed [MUL_B_W-1:0]       op_b;
  logic signed [PROD_W-1:0]        mq;
  logic signed [ACC_W-1:0]         mq_ext;
  logic signed [ACC_W-1:0]         acc;
  logic signed [DATA_W-1:0]        raw, x1, x2, y1, y2, y_new;
  logic signed [XS_W-1:0]          xs, xs_next;
  logic [DATA_W-1:0]               vmag, amag;
  logic [SQ_W-1:0]                 vsq, asq;
  logic                            vbig, abig;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC - 1);

  assign pos_s   = pos[POSITION_BITS-1:0];
  assign d1_next = (POSITION_BITS+1)'(pos_s) - (POSITION_BITS+1)'(p0);
  assign d2_next = (POSITION_BITS+2)'(pos_s) - ((POSITION_BITS+2)'(p0) <<< 1)
                 + (POSITION_BITS+2)'(p1);
  assign mq_ext  = ACC_W'(mq);
  assign xs_next = XS_W'(raw) + (XS_W'(x1) <<< 1) + XS_W'(x2);
  assign y_new   = sat48((acc + HALF) >>> COEF_FRAC);
  assign vmag    = vel[DATA_W-1] ? DATA_W'(-vel) : DATA_W'(vel);
  assign amag    = filt[DATA_W-1] ? DATA_W'(-filt) : DATA_W'(filt);
  assign mag     = '{vsq: vsq, vbig: vbig, asq: asq, abig: abig};

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl.step)
      STEP_MUL_VEL: begin
        op_a = MUL_A_W'($signed({1'b0, coef.rate}));
        op_b = MUL_B_W'(d1);
      end
      STEP_MUL_RAW: begin
        op_a = MUL_A_W'($signed({1'b0, coef.rate_sq}));
        op_b = MUL_B_W'(d2);
      end
      STEP_MUL_A1_LO: begin
        op_a = MUL_A_W'(coef.a1);
        op_b = MUL_B_W'(y1[SPLIT-1:0]);
      end
      STEP_MUL_A1_HI: begin
        op_a = MUL_A_W'(coef.a1);
        op_b = MUL_B_W'(y1 >>> SPLIT);
      end
      STEP_MUL_A2_LO: begin
        op_a = MUL_A_W'(coef.a2);
        op_b = MUL_B_W'(y2[SPLIT-1:0]);
      end
      STEP_MUL_A2_HI: begin
        op_a = MUL_A_W'(coef.a2);
        op_b = MUL_B_W'(y2 >>> SPLIT);
      end
      STEP_MUL_B0_LO: begin
        op_a = MUL_A_W'(coef.b0);
        op_b = MUL_B_W'(xs[SPLIT-1:0]);
      end
      STEP_MUL_B0_HI: begin
        op_a = MUL_A_W'(coef.b0);
        op_b = MUL_B_W'(xs >>> SPLIT);
      end
      STEP_MUL_VSQ: begin
        op_a = MUL_A_W'(vmag[MAG_LOW_W-1:0]);
        op_b = MUL_B_W'(vmag[MAG_LOW_W-1:0]);
      end
      STEP_MUL_ASQ: begin
        op_a = MUL_A_W'(amag[MAG_LOW_W-1:0]);
        op_b = MUL_B_W'(amag[MAG_LOW_W-1:0]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mq <= op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0   <= '0;
      p1   <= '0;
      d1   <= '0;
      d2   <= '0;
      x1   <= '0;
      x2   <= '0;
      y1   <= '0;
      y2   <= '0;
      vel  <= '0;
      filt <= '0;
      raw  <= '0;
      xs   <= '0;
      acc  <= '0;
      vsq  <= '0;
      asq  <= '0;
      vbig <= 1'b0;
      abig <= 1'b0;
    end else begin
      if (ctrl.start) begin
        p1 <= p0;
        p0 <= pos_s;
        d1 <= d1_next;
        d2 <= d2_next;
      end
      if (ctrl.run) begin
        case (ctrl.step)
          STEP_MUL_RAW: begin
            if (ctrl.do_vel) begin
              vel <= sat48(mq_ext);
            end
          end
          STEP_MUL_A1_LO: raw <= sat48(mq_ext);
          STEP_MUL_A1_HI: begin
            acc <= -mq_ext;
            xs  <= xs_next;
          end
          STEP_MUL_A2_LO: acc <= acc - (mq_ext <<< SPLIT);
          STEP_MUL_A2_HI: acc <= acc - mq_ext;
          STEP_MUL_B0_LO: acc <= acc - (mq_ext <<< SPLIT);
          STEP_MUL_B0_HI: acc <= acc + mq_ext;
          STEP_MUL_VSQ:   acc <= acc + (mq_ext <<< SPLIT);
          STEP_FILT: begin
            vsq  <= mq[SQ_W-1:0];
            vbig <= |vmag[DATA_W-1:MAG_LOW_W];
            if (ctrl.do_acc) begin
              x2   <= x1;
              x1   <= raw;
              y2   <= y1;
              y1   <= y_new;
              filt <= y_new;
            end
          end
          STEP_LAST: begin
            asq  <= mq[SQ_W-1:0];
            abig <= |amag[DATA_W-1:MAG_LOW_W];
          end
          default: ;
        endcase
      end
    end
  end

endmodule

>>> src/mebs_merge.sv
`timescale 1ns / 1ps
// Merge stage: combines lane magnitudes into the still flag and holds the result register.
module mebs_merge import mebs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic signed [DATA_W-1:0] lane_vel [NUM_AXES],
  input  logic signed [DATA_W-1:0] lane_acc [NUM_AXES],
  input  mag_t                     lane_mag [NUM_AXES],
  input  logic [SQ_W-1:0]          vel_thr_sq,
  input  logic [SQ_W-1:0]          acc_thr_sq,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] vel_x,
  output logic signed [DATA_W-1:0] vel_y,
  output logic signed [DATA_W-1:0] vel_z,
  output logic signed [DATA_W-1:0] acc_x,
  output logic signed [DATA_W-1:0] acc_y,
  output logic signed [DATA_W-1:0] acc_z,
  output logic                     still
);

  logic [SQ_W+1:0] vsum, asum;
  logic            any_big;
  logic            still_next;

  always_comb begin
    vsum    = '0;
    asum    = '0;
    any_big = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      vsum    = vsum + (SQ_W+2)'(lane_mag[i].vsq);
      asum    = asum + (SQ_W+2)'(lane_mag[i].asq);
      any_big = any_big | lane_mag[i].vbig | lane_mag[i].abig;
    end
    still_next = !any_big && (vsum < (SQ_W+2)'(vel_thr_sq))
               && (asum < (SQ_W+2)'(acc_thr_sq));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vel_x <= lane_vel[0];
      vel_y <= lane_vel[1];
      vel_z <= lane_vel[2];
      acc_x <= lane_acc[0];
      acc_y <= lane_acc[1];
      acc_z <= lane_acc[2];
      still <= still_next;
    end
  end

endmodule

>>> src/motion_estimator_biquad_still.sv
`timescale 1ns / 1ps
// Top level: motion estimator with biquad-filtered acceleration and still detection.
// Schedule: an accepted input transaction runs the twelve-step schedule on the single
// 33x35 multiplier in each axis lane, then the merge state loads the result register.
// A new transaction is taken only after the merge; the merge waits on a stalled result.
// Reset (rst, synchronous): clears history, filter state, sample count and output valid;
// registers return to sample rate 1000 and zero coefficients and thresholds.
module motion_estimator_biquad_still import mebs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [31:0]              pos_x,
  input  logic [31:0]              pos_y,
  input  logic [31:0]              pos_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] vel_x,
  output logic signed [DATA_W-1:0] vel_y,
  output logic signed [DATA_W-1:0] vel_z,
  output logic signed [DATA_W-1:0] acc_x,
  output logic signed [DATA_W-1:0] acc_y,
  output logic signed [DATA_W-1:0] acc_z,
  output logic                     still,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [31:0]              cfg_data
);

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic [2:0]        count;
  logic              accept;
  logic              load;
  coef_t             coef;
  logic [SQ_W-1:0]   vel_thr_sq, acc_thr_sq;
  lane_ctrl_t        ctrl;

  logic [31:0]              pos_arr  [NUM_AXES];
  logic signed [DATA_W-1:0] lane_vel [NUM_AXES];
  logic signed [DATA_W-1:0] lane_acc [NUM_AXES];
  mag_t                     lane_mag [NUM_AXES];

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.rate    <= RATE_RESET;
      coef.rate_sq <= RATE_SQ_RESET;
      coef.b0      <= '0;
      coef.a1      <= '0;
      coef.a2      <= '0;
      vel_thr_sq   <= '0;
      acc_thr_sq   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLE_RATE: begin
          coef.rate    <= cfg_data[15:0];
          coef.rate_sq <= {16'b0, cfg_data[15:0]} * {16'b0, cfg_data[15:0]};
        end
        REG_LPF_B0:  coef.b0 <= cfg_data;
        REG_LPF_A1:  coef.a1 <= cfg_data;
        REG_LPF_A2:  coef.a2 <= cfg_data;
        REG_VEL_THR: vel_thr_sq <= {32'b0, cfg_data} * {32'b0, cfg_data};
        REG_ACC_THR: acc_thr_sq <= {32'b0, cfg_data} * {32'b0, cfg_data};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (accept && (count < COUNT_MAX)) begin
        count <= count + 3'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    in_stall   = 1'b1;
    load       = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall  = 1'b0;
        step_next = STEP_MUL_VEL;
        if (in_valid) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (step == STEP_LAST) begin
          state_next = S_MERGE;
        end else begin
          step_next = step + 4'd1;
        end
      end
      S_MERGE: begin
        if (!out_valid || !out_stall) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign ctrl = '{start:  accept,
                  run:    (state == S_RUN),
                  step:   step,
                  do_vel: (count >= VEL_COUNT),
                  do_acc: (count >= ACC_COUNT)};

  assign pos_arr[0] = pos_x;
  assign pos_arr[1] = pos_y;
  assign pos_arr[2] = pos_z;

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    mebs_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .pos  (pos_arr[i]),
      .ctrl (ctrl),
      .coef (coef),
      .vel  (lane_vel[i]),
      .filt (lane_acc[i]),
      .mag  (lane_mag[i])
    );
  end

  mebs_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .lane_vel   (lane_vel),
    .lane_acc   (lane_acc),
    .lane_mag   (lane_mag),
    .vel_thr_sq (vel_thr_sq),
    .acc_thr_sq (acc_thr_sq),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .vel_x      (vel_x),
    .vel_y      (vel_y),
    .vel_z      (vel_z),
    .acc_x      (acc_x),
    .acc_y      (acc_y),
    .acc_z      (acc_z),
    .still      (still)
  );

endmodule

>>> src/mebs_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the motion estimator, bound to the top level.
module mebs_checker import mebs_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] vel_x,
  input logic signed [DATA_W-1:0] acc_x,
  input logic                     still
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted transaction");

  a_result_needs_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a transaction in progress");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("output valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(vel_x) && $stable(acc_x) && $stable(still)))
    else $error("output payload changed while stalled");

endmodule

bind motion_estimator_biquad_still mebs_checker u_mebs_checker (.*);

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the motion estimator with biquad lowpass and still flag.
module testbench;
  import mebs_pkg::*;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  typedef struct packed {
    logic [DATA_W-1:0] vel_x;
    logic [DATA_W-1:0] vel_y;
    logic [DATA_W-1:0] vel_z;
    logic [DATA_W-1:0] acc_x;
    logic [DATA_W-1:0] acc_y;
    logic [DATA_W-1:0] acc_z;
    logic              still;
  } motion_t;

  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam logic signed [127:0] SAT_HI = (128'sd1 <<< (DATA_W - 1)) - 128'sd1;
  localparam logic signed [127:0] SAT_LO = -(128'sd1 <<< (DATA_W - 1));
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] POS_MIN = 32'h8000_0000;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] pos_x = '0;
  logic [31:0] pos_y = '0;
  logic [31:0] pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] vel_x, vel_y, vel_z;
  logic signed [DATA_W-1:0] acc_x, acc_y, acc_z;
  logic still;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  motion_estimator_biquad_still uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
    .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
    .still(still),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor registers and state
  logic [15:0]        rate_hz;
  logic signed [31:0] coef_b0, coef_a1, coef_a2;
  logic [31:0]        speed_limit, accel_limit;
  logic signed [31:0] pos_hist [3][3];
  logic [2:0]         samples_seen;
  logic signed [DATA_W-1:0] held_vel [3];
  logic signed [DATA_W-1:0] filt_acc [3];
  logic signed [DATA_W-1:0] raw_hist [3][2];
  logic signed [DATA_W-1:0] out_hist [3][2];

  motion_t expected_motion [$];
  int error_count = 0;
  int burst_left = 0;
  bit gaps_on = 1'b0;
  stall_mode_t stall_mode = STALL_NONE;
  logic [4:0] stall_phase = '0;
  int track [3];
  int drift [3];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    stall_phase <= stall_phase + 5'd1;
    case (stall_mode)
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= (stall_phase[4:3] == 2'b11);
      default:        out_stall <= 1'b0;
    endcase
  end

  function automatic logic signed [DATA_W-1:0] clip48(input logic signed [127:0] v);
    if (v > SAT_HI) return SAT_HI[DATA_W-1:0];
    if (v < SAT_LO) return SAT_LO[DATA_W-1:0];
    return v[DATA_W-1:0];
  endfunction

  function automatic logic [127:0] square_sum(input logic signed [DATA_W-1:0] a, b, c);
    logic signed [127:0] ea, eb, ec;
    ea = a;
    eb = b;
    ec = c;
    return ea * ea + eb * eb + ec * ec;
  endfunction

  task automatic clear_model;
    rate_hz = RATE_RESET;
    coef_b0 = '0;
    coef_a1 = '0;
    coef_a2 = '0;
    speed_limit = '0;
    accel_limit = '0;
    samples_seen = '0;
    for (int k = 0; k < 3; k++) begin
      for (int s = 0; s < 3; s++) pos_hist[s][k] = '0;
      held_vel[k] = '0;
      filt_acc[k] = '0;
      raw_hist[k][0] = '0;
      raw_hist[k][1] = '0;
      out_hist[k][0] = '0;
      out_hist[k][1] = '0;
      track[k] = 0;
      drift[k] = 0;
    end
  endtask

  task automatic estimate_motion(input logic [31:0] px, py, pz);
    logic [31:0] p [3];
    logic signed [127:0] rate_w, rate_sq_w, d1, d2, xs, sum, rounded;
    logic signed [DATA_W-1:0] raw, y;
    logic [127:0] lim, vthr_sq, athr_sq;
    motion_t r;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    for (int k = 0; k < 3; k++) begin
      pos_hist[2][k] = pos_hist[1][k];
      pos_hist[1][k] = pos_hist[0][k];
      pos_hist[0][k] = $signed(p[k][POSITION_BITS-1:0]);
    end
    if (samples_seen < COUNT_MAX) samples_seen = samples_seen + 3'd1;
    rate_w = {112'd0, rate_hz};
    rate_sq_w = rate_w * rate_w;
    if (samples_seen >= VEL_COUNT) begin
      for (int k = 0; k < 3; k++) begin
        d1 = pos_hist[0][k] - pos_hist[1][k];
        held_vel[k] = clip48(d1 * rate_w);
      end
    end
    if (samples_seen >= ACC_COUNT) begin
      for (int k = 0; k < 3; k++) begin
        d2 = pos_hist[0][k] - 2 * pos_hist[1][k] + pos_hist[2][k];
        raw = clip48(d2 * rate_sq_w);
        xs = raw + 2 * raw_hist[k][0] + raw_hist[k][1];
        sum = coef_b0 * xs - coef_a1 * out_hist[k][0] - coef_a2 * out_hist[k][1];
        rounded = (sum + (128'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
        y = clip48(rounded);
        raw_hist[k][1] = raw_hist[k][0];
        raw_hist[k][0] = raw;
        out_hist[k][1] = out_hist[k][0];
        out_hist[k][0] = y;
        filt_acc[k] = y;
      end
    end
    lim = {96'd0, speed_limit};
    vthr_sq = lim * lim;
    lim = {96'd0, accel_limit};
    athr_sq = lim * lim;
    r.vel_x = held_vel[0];
    r.vel_y = held_vel[1];
    r.vel_z = held_vel[2];
    r.acc_x = filt_acc[0];
    r.acc_y = filt_acc[1];
    r.acc_z = filt_acc[2];
    r.still = (square_sum(held_vel[0], held_vel[1], held_vel[2]) < vthr_sq) &&
              (square_sum(filt_acc[0], filt_acc[1], filt_acc[2]) < athr_sq);
    expected_motion.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want, got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    motion_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_motion.size() == 0) begin
        $display("%0t unexpected transaction: expected none, actual vel %h %h %h", $time,
                 vel_x, vel_y, vel_z);
        error_count++;
      end else begin
        e = expected_motion.pop_front();
        check_field("vel_x", e.vel_x, vel_x);
        check_field("vel_y", e.vel_y, vel_y);
        check_field("vel_z", e.vel_z, vel_z);
        check_field("acc_x", e.acc_x, acc_x);
        check_field("acc_y", e.acc_y, acc_y);
        check_field("acc_z", e.acc_z, acc_z);
        check_field("still", {47'd0, e.still}, {47'd0, still});
      end
    end
  end

  task automatic send_sample(input logic [31:0] px, py, pz);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    do @(posedge clk); while (in_stall);
    estimate_motion(px, py, pz);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    while (expected_motion.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SAMPLE_RATE: rate_hz = data[15:0];
      REG_LPF_B0:      coef_b0 = data;
      REG_LPF_A1:      coef_a1 = data;
      REG_LPF_A2:      coef_a2 = data;
      REG_VEL_THR:     speed_limit = data;
      REG_ACC_THR:     accel_limit = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [31:0] rate, b0, a1, a2, vthr, athr);
    write_reg(REG_SAMPLE_RATE, rate);
    write_reg(REG_LPF_B0, b0);
    write_reg(REG_LPF_A1, a1);
    write_reg(REG_LPF_A2, a2);
    write_reg(REG_VEL_THR, vthr);
    write_reg(REG_ACC_THR, athr);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_early_samples;
    gaps_on = 1'b1;
    stall_mode <= STALL_LIGHT;
    send_sample(32'd10, 32'd20, 32'd30);
    send_sample(32'd15, 32'd18, 32'd30);
    send_sample(32'd25, 32'd16, 32'd29);
    send_sample(32'd40, 32'd14, 32'd27);
    send_sample(32'd60, 32'd11, 32'd26);
  endtask

  task automatic test_saturation;
    wait_drained;
    program_regs(32'd65535, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    stall_mode <= STALL_HEAVY;
    send_sample(POS_MAX, POS_MIN, 32'd0);
    send_sample(POS_MIN, POS_MAX, 32'hFFFF_FFFF);
    send_sample(POS_MAX, POS_MIN, 32'd0);
    send_sample(POS_MIN, POS_MAX, POS_MAX);
    send_sample(32'd0, 32'hFFFF_FFFF, POS_MIN);
    send_sample(32'hFFFF_FFFF, 32'd0, POS_MAX);
  endtask

  task automatic test_zero_rate;
    wait_drained;
    program_regs(32'd0, 32'h8000_0000, 32'd0, 32'd0, 32'd1, 32'd1);
    stall_mode <= STALL_PERIODIC;
    send_sample(32'd5, 32'd7, 32'd9);
    send_sample(32'd900, 32'hFFFF_FF00, 32'd9);
    send_sample(32'd1, 32'd2, 32'd3);
  endtask

  task automatic test_still_threshold;
    wait_drained;
    program_regs(32'd1, 32'h1000_0000, 32'd0, 32'd0, 32'd5, 32'd5);
    stall_mode <= STALL_NONE;
    gaps_on = 1'b0;
    send_sample(32'd100, 32'd100, 32'd100);
    send_sample(32'd100, 32'd100, 32'd100);
    send_sample(32'd100, 32'd100, 32'd100);
    send_sample(32'd102, 32'd102, 32'd102);
    send_sample(32'd105, 32'd105, 32'd105);
  endtask

  task automatic test_spare_index;
    wait_drained;
    write_reg(REG_SPARE_LO, 32'd0);
    write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    gaps_on = 1'b1;
    send_sample(32'd105, 32'd105, 32'd105);
    send_sample(32'd104, 32'd106, 32'd105);
  endtask

  task automatic pick_setup(input int span);
    logic [31:0] rate, b0, a1, a2, vthr, athr;
    int mag;
    case ($urandom_range(0, 5))
      0: rate = 32'd1;
      1: rate = 32'd65535;
      2: rate = 32'd0;
      default: rate = $urandom_range(200, 2000);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      b0 = $urandom;
      a1 = $urandom;
      a2 = $urandom;
    end else begin
      b0 = $urandom_range(0, 1 << 26);
      mag = $urandom_range(0, 1 << 30);
      a1 = -mag;
      a2 = $urandom_range(0, 1 << 29);
    end
    case ($urandom_range(0, 5))
      0: vthr = 32'd0;
      1: vthr = 32'hFFFF_FFFF;
      default: vthr = $urandom_range(0, span * 2000 + 10);
    endcase
    case ($urandom_range(0, 5))
      0: athr = 32'd0;
      1: athr = 32'hFFFF_FFFF;
      default: athr = $urandom_range(0, span * 1_000_000 + 10);
    endcase
    program_regs(rate, b0, a1, a2, vthr, athr);
  endtask

  task automatic next_sample(input int span, output logic [31:0] px, py, pz);
    logic [31:0] p [3];
    int pick;
    pick = $urandom_range(0, 19);
    for (int k = 0; k < 3; k++) begin
      if (pick == 0) begin
        p[k] = $urandom;
      end else if (pick == 1) begin
        case ($urandom_range(0, 3))
          0: p[k] = POS_MAX;
          1: p[k] = POS_MIN;
          2: p[k] = 32'd0;
          default: p[k] = 32'hFFFF_FFFF;
        endcase
      end else begin
        if ($urandom_range(0, 15) == 0) drift[k] = 0;
        else drift[k] = drift[k] + $urandom_range(0, 2) - 1;
        if (drift[k] > span) drift[k] = span;
        if (drift[k] < -span) drift[k] = -span;
        track[k] = track[k] + drift[k];
        p[k] = track[k];
      end
    end
    px = p[0];
    py = p[1];
    pz = p[2];
  endtask

  task automatic test_random_traffic;
    logic [31:0] px, py, pz;
    int span;
    for (int phase = 0; phase < 8; phase++) begin
      span = 1 << $urandom_range(0, 10);
      wait_drained;
      pick_setup(span);
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 125; n++) begin
        next_sample(span, px, py, pz);
        send_sample(px, py, pz);
      end
    end
  endtask

  initial begin
    clear_model;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_early_samples;
    test_saturation;
    test_zero_rate;
    test_still_threshold;
    test_spare_index;
    test_random_traffic;
    wait_drained;
    stall_mode <= STALL_NONE;
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
